@@ rtl/core/slms_pkg.sv @@
// Shared constants for the segmented linear move sequencer.
// Holds field widths, configuration register codes and output flag positions.
// No dependencies.
package slms_pkg;

  localparam int unsigned DEF_MAX_SEGMENTS = 65535;
  localparam int unsigned DEF_POS_BITS     = 24;

  localparam int unsigned STEP_FRAC = 15;
  localparam int unsigned FEED_W    = 20;
  localparam int unsigned SPEED_W   = 21;
  localparam int unsigned CFG_W     = 10;
  localparam int unsigned SEG_DIV   = 1000;
  localparam int unsigned SEG_DIV_W = 10;

  localparam logic [CFG_W-1:0] SPM_RESET = CFG_W'(10);
  localparam logic [CFG_W-1:0] TOL_RESET = CFG_W'(10);

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPM = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOL = 1'b1;

  // Result flag positions in m_axis_tuser
  localparam int unsigned USR_W    = 3;
  localparam int unsigned USR_CV   = 0;
  localparam int unsigned USR_MOV  = 1;
  localparam int unsigned USR_DONE = 2;

endpackage

@@ rtl/core/segmented_linear_move_sequencer_core.sv @@
// Segmented 3-axis straight-line move sequencer, top level.
// Start: sum of squared deltas, root, then divisions for segment count, axis steps and axis
// speeds (a zero-length move skips the speed divisions), all on the one-bit-per-cycle root
// and divider; tick: reach check, plus the next segment end when it advances.
// One item at a time: ready again as the result is registered, later while the
// result waits. Reset (rst_ni low, asynchronous): no move, registers at 10 and 10.
module segmented_linear_move_sequencer_core
  import slms_pkg::*;
#(
  parameter int unsigned MAX_SEGMENTS = DEF_MAX_SEGMENTS,
  parameter int unsigned POS_BITS     = DEF_POS_BITS
) (
  input  logic clk_i,
  input  logic rst_ni,
  // target X, target Y, target Z, feed speed, current X, current Y, current Z; zero pad
  input  logic [((6*POS_BITS+FEED_W+7)/8)*8-1:0] s_axis_tdata,
  // mode
  input  logic                                   s_axis_tuser,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // next_x, next_y, next_z, axis_speed_x, axis_speed_y, axis_speed_z; zero pad
  output logic [((3*POS_BITS+3*SPEED_W+7)/8)*8-1:0] m_axis_tdata,
  // command_valid, is_moving, done_res
  output logic [USR_W-1:0]                          m_axis_tuser,
  output logic                                      m_axis_tvalid,
  input  logic                                      m_axis_tready,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned P       = POS_BITS;
  localparam int unsigned D_W     = P + 1;
  localparam int unsigned SQ_W    = (2*P + 4 > 64) ? 64 : 2*P + 4;
  localparam int unsigned DIST_W  = SQ_W / 2;
  localparam int unsigned SEG_W   = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned STEP_W  = P + STEP_FRAC + 1;
  localparam int unsigned RND_W   = STEP_W - STEP_FRAC;
  localparam int unsigned END_W   = P + 2;
  localparam int unsigned DIV_W   = P + FEED_W + 1;
  localparam int unsigned DVS_A   = (DIST_W > SEG_W) ? DIST_W : SEG_W;
  localparam int unsigned DVS_W   = (DVS_A > SEG_DIV_W) ? DVS_A : SEG_DIV_W;
  localparam int unsigned CNT_W   = $clog2(DIV_W + 1);
  localparam int unsigned OUT_BIT = 3*P + 3*SPEED_W;
  localparam int unsigned OUT_W   = ((OUT_BIT + 7) / 8) * 8;

  // Sequencer states
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SQ    = 4'd1;
  localparam logic [3:0] ST_SQRT  = 4'd2;
  localparam logic [3:0] ST_DPREP = 4'd3;
  localparam logic [3:0] ST_DIV   = 4'd4;
  localparam logic [3:0] ST_DPOST = 4'd5;
  localparam logic [3:0] ST_END   = 4'd6;
  localparam logic [3:0] ST_TICK  = 4'd7;
  localparam logic [3:0] ST_FIN   = 4'd8;

  // Divider jobs
  localparam logic [1:0] OP_SEGS  = 2'd0;
  localparam logic [1:0] OP_STEP  = 2'd1;
  localparam logic [1:0] OP_SPEED = 2'd2;

  localparam logic [1:0] AX_LAST = 2'd2;

  logic [3:0]  state_q;
  logic [1:0]  op_q;
  logic [1:0]  axis_q;
  logic [CNT_W-1:0] cnt_q;

  logic [CFG_W-1:0] spm_q;
  logic [CFG_W-1:0] tol_q;

  logic signed [P-1:0]      cur_q    [3];
  logic signed [D_W-1:0]    d_q      [3];
  logic [FEED_W-1:0]        feed_q;
  logic signed [P-1:0]      origin_q [3];
  logic signed [STEP_W-1:0] step_q   [3];
  logic signed [STEP_W-1:0] acc_q    [3];
  logic signed [END_W-1:0]  end_q    [3];
  logic signed [SPEED_W-1:0] speed_q [3];
  logic [SEG_W-1:0]         total_q;
  logic [SEG_W-1:0]         idx_q;
  logic                     busy_q;

  logic [SQ_W-1:0]     sq_q;
  logic [DIST_W+1:0]   rem_q;
  logic [DIST_W-1:0]   root_q;

  logic [DIV_W-1:0]    dvd_q;
  logic [DVS_W-1:0]    drem_q;
  logic [DVS_W-1:0]    dvs_q;
  logic                dneg_q;

  logic res_cv_q, res_mov_q, res_done_q, res_zero_q;

  logic               m_valid_q;
  logic [OUT_W-1:0]   m_data_q;
  logic [USR_W-1:0]   m_user_q;

  // Input unpacking
  logic signed [P-1:0] in_tgt [3];
  logic signed [P-1:0] in_cur [3];
  logic [FEED_W-1:0]   in_feed;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      in_tgt[a] = s_axis_tdata[a*P +: P];
      in_cur[a] = s_axis_tdata[3*P + FEED_W + a*P +: P];
    end
    in_feed = s_axis_tdata[3*P +: FEED_W];
  end

  // Root step: two radicand bits per cycle, one root bit out
  logic [DIST_W+2:0] rt_sh;
  logic [DIST_W+2:0] rt_trial;
  logic              rt_ge;

  always_comb begin
    rt_sh    = {rem_q[DIST_W:0], sq_q[SQ_W-1 -: 2]};
    rt_trial = {1'b0, root_q, 2'b01};
    rt_ge    = (rt_sh >= rt_trial);
  end

  // Divider step: restoring, one quotient bit per cycle
  logic [DVS_W:0] dv_sh;
  logic           dv_ge;

  always_comb begin
    dv_sh = {drem_q, dvd_q[DIV_W-1]};
    dv_ge = (dv_sh >= {1'b0, dvs_q});
  end

  // Divider operand selection for the current job
  logic signed [D_W-1:0] dsel;
  logic [D_W-1:0]        dmag;
  logic [2*D_W-1:0]      sq_term;
  logic [DIV_W-1:0]      prep_dvd;
  logic [DVS_W-1:0]      prep_dvs;

  always_comb begin
    dsel    = d_q[axis_q];
    dmag    = dsel[D_W-1] ? D_W'(-dsel) : D_W'(dsel);
    sq_term = {{D_W{1'b0}}, dmag} * {{D_W{1'b0}}, dmag};
    unique case (op_q)
      OP_SEGS: begin
        prep_dvd = DIV_W'(root_q) * DIV_W'(spm_q);
        prep_dvs = DVS_W'(SEG_DIV);
      end
      OP_STEP: begin
        prep_dvd = DIV_W'({dmag, {STEP_FRAC{1'b0}}});
        prep_dvs = DVS_W'(total_q);
      end
      default: begin
        prep_dvd = DIV_W'(feed_q) * DIV_W'(dmag);
        prep_dvs = DVS_W'(root_q);
      end
    endcase
  end

  // Quotient post-processing
  logic signed [DIV_W:0] q_signed;
  logic [SEG_W-1:0]      segs_clamp;

  always_comb begin
    q_signed = dneg_q ? -$signed({1'b0, dvd_q}) : $signed({1'b0, dvd_q});
    if (dvd_q == '0) begin
      segs_clamp = SEG_W'(1);
    end else if (dvd_q > DIV_W'(MAX_SEGMENTS)) begin
      segs_clamp = SEG_W'(MAX_SEGMENTS);
    end else begin
      segs_clamp = dvd_q[SEG_W-1:0];
    end
  end

  // Segment ends: origin plus step*k rounded half away from zero
  logic [STEP_W-1:0]      acc_mag [3];
  logic [STEP_W-1:0]      acc_rnd [3];
  logic signed [END_W-1:0] end_calc [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      acc_mag[a] = acc_q[a][STEP_W-1] ? STEP_W'(-acc_q[a]) : STEP_W'(acc_q[a]);
      acc_rnd[a] = (acc_mag[a] + STEP_W'(1 << (STEP_FRAC - 1))) >> STEP_FRAC;
      end_calc[a] = END_W'(origin_q[a]) + (acc_q[a][STEP_W-1]
                    ? -$signed(END_W'(acc_rnd[a][RND_W-1:0]))
                    :  $signed(END_W'(acc_rnd[a][RND_W-1:0])));
    end
  end

  // Reach check on a tick
  logic signed [END_W:0] tk_diff [3];
  logic [END_W:0]        tk_abs  [3];
  logic                  reached;
  logic [SEG_W:0]        k_next;

  always_comb begin
    reached = 1'b1;
    for (int a = 0; a < 3; a++) begin
      tk_diff[a] = (END_W+1)'(cur_q[a]) - (END_W+1)'(end_q[a]);
      tk_abs[a]  = tk_diff[a][END_W] ? (END_W+1)'(-tk_diff[a]) : (END_W+1)'(tk_diff[a]);
      if (tk_abs[a] >= (END_W+1)'(tol_q)) begin
        reached = 1'b0;
      end
    end
    k_next = (SEG_W+1)'(idx_q) + (SEG_W+1)'(1);
  end

  // Output payload
  logic [OUT_W-1:0] out_pack;

  always_comb begin
    out_pack = '0;
    for (int a = 0; a < 3; a++) begin
      out_pack[a*P +: P]             = end_q[a][P-1:0];
      out_pack[3*P + a*SPEED_W +: SPEED_W] = speed_q[a];
    end
  end

  logic s_fire;
  assign s_fire = s_axis_tvalid && s_axis_tready;

  // Load the result register when it is empty or its transfer happens now
  logic out_load;
  assign out_load = (state_q == ST_FIN) && (!m_valid_q || m_axis_tready);

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spm_q <= SPM_RESET;
      tol_q <= TOL_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_IDX_SPM: spm_q <= cfg_data_i;
        default:     tol_q <= cfg_data_i;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      busy_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_fire) begin
            if (!s_axis_tuser) begin
              busy_q  <= 1'b1;
              state_q <= ST_SQ;
            end else if (busy_q) begin
              state_q <= ST_TICK;
            end else begin
              state_q <= ST_FIN;
            end
          end
        end
        ST_SQ:    if (axis_q == AX_LAST) state_q <= ST_SQRT;
        ST_SQRT:  if (cnt_q == CNT_W'(1)) state_q <= ST_DPREP;
        ST_DPREP: state_q <= ST_DIV;
        ST_DIV:   if (cnt_q == CNT_W'(1)) state_q <= ST_DPOST;
        ST_DPOST: begin
          priority if (op_q == OP_SEGS) begin
            state_q <= ST_DPREP;
          end else if (axis_q != AX_LAST) begin
            state_q <= ST_DPREP;
          end else if (op_q == OP_STEP && root_q != '0) begin
            state_q <= ST_DPREP;
          end else begin
            state_q <= ST_END;
          end
        end
        ST_END: state_q <= ST_FIN;
        ST_TICK: begin
          if (!reached) begin
            state_q <= ST_FIN;
          end else if (k_next >= (SEG_W+1)'(total_q)) begin
            busy_q  <= 1'b0;
            state_q <= ST_FIN;
          end else begin
            state_q <= ST_END;
          end
        end
        ST_FIN: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath: shared root and divider units, move state, result register
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          for (int a = 0; a < 3; a++) begin
            cur_q[a] <= in_cur[a];
          end
          axis_q <= '0;
          if (!s_axis_tuser) begin
            for (int a = 0; a < 3; a++) begin
              origin_q[a] <= in_cur[a];
              d_q[a]      <= D_W'(in_tgt[a]) - D_W'(in_cur[a]);
            end
            feed_q <= in_feed;
            idx_q  <= '0;
            sq_q   <= '0;
            res_cv_q   <= 1'b1;
            res_mov_q  <= 1'b1;
            res_done_q <= 1'b0;
            res_zero_q <= 1'b0;
          end else if (!busy_q) begin
            res_cv_q   <= 1'b0;
            res_mov_q  <= 1'b0;
            res_done_q <= 1'b0;
            res_zero_q <= 1'b1;
          end
        end
      end
      ST_SQ: begin
        // accumulate one axis square per cycle on a shared multiplier
        sq_q   <= sq_q + SQ_W'(sq_term);
        axis_q <= axis_q + 2'd1;
        if (axis_q == AX_LAST) begin
          cnt_q  <= CNT_W'(DIST_W);
          rem_q  <= '0;
          root_q <= '0;
        end
      end
      ST_SQRT: begin
        sq_q  <= sq_q << 2;
        cnt_q <= cnt_q - CNT_W'(1);
        if (rt_ge) begin
          rem_q  <= (DIST_W+2)'(rt_sh - rt_trial);
          root_q <= {root_q[DIST_W-2:0], 1'b1};
        end else begin
          rem_q  <= rt_sh[DIST_W+1:0];
          root_q <= {root_q[DIST_W-2:0], 1'b0};
        end
        if (cnt_q == CNT_W'(1)) begin
          op_q   <= OP_SEGS;
          axis_q <= '0;
        end
      end
      ST_DPREP: begin
        dvd_q  <= prep_dvd;
        dvs_q  <= prep_dvs;
        drem_q <= '0;
        dneg_q <= (op_q != OP_SEGS) && dsel[D_W-1];
        cnt_q  <= CNT_W'(DIV_W);
      end
      ST_DIV: begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (dv_ge) begin
          drem_q <= DVS_W'(dv_sh - {1'b0, dvs_q});
        end else begin
          drem_q <= dv_sh[DVS_W-1:0];
        end
        dvd_q <= {dvd_q[DIV_W-2:0], dv_ge};
      end
      ST_DPOST: begin
        unique case (op_q)
          OP_SEGS: begin
            total_q <= segs_clamp;
            op_q    <= OP_STEP;
            axis_q  <= '0;
          end
          OP_STEP: begin
            step_q[axis_q] <= q_signed[STEP_W-1:0];
            acc_q[axis_q]  <= q_signed[STEP_W-1:0];
            if (axis_q != AX_LAST) begin
              axis_q <= axis_q + 2'd1;
            end else if (root_q != '0) begin
              op_q   <= OP_SPEED;
              axis_q <= '0;
            end else begin
              for (int a = 0; a < 3; a++) begin
                speed_q[a] <= '0;
              end
            end
          end
          default: begin
            speed_q[axis_q] <= q_signed[SPEED_W-1:0];
            axis_q <= axis_q + 2'd1;
          end
        endcase
      end
      ST_END: begin
        for (int a = 0; a < 3; a++) begin
          end_q[a] <= end_calc[a];
        end
      end
      ST_TICK: begin
        if (!reached) begin
          res_cv_q   <= 1'b0;
          res_mov_q  <= 1'b1;
          res_done_q <= 1'b0;
          res_zero_q <= 1'b0;
        end else begin
          idx_q <= k_next[SEG_W-1:0];
          if (k_next >= (SEG_W+1)'(total_q)) begin
            res_cv_q   <= 1'b0;
            res_mov_q  <= 1'b0;
            res_done_q <= 1'b1;
            res_zero_q <= 1'b1;
          end else begin
            // advance to the next segment end
            for (int a = 0; a < 3; a++) begin
              acc_q[a] <= acc_q[a] + step_q[a];
            end
            res_cv_q   <= 1'b1;
            res_mov_q  <= 1'b1;
            res_done_q <= 1'b0;
            res_zero_q <= 1'b0;
          end
        end
      end
      ST_FIN: begin
        if (out_load) begin
          m_data_q <= res_zero_q ? '0 : out_pack;
          m_user_q[USR_CV]   <= res_cv_q;
          m_user_q[USR_MOV]  <= res_mov_q;
          m_user_q[USR_DONE] <= res_done_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

@@ rtl/core/slms_checker.sv @@
// Port-level checker for the segmented linear move sequencer, with its bind.
// Uses slms_pkg; attaches to segmented_linear_move_sequencer_core.
module slms_checker
  import slms_pkg::*;
#(
  parameter int unsigned OUT_W = 136
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata,
  input logic [USR_W-1:0] m_axis_tuser,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready
);

  // hold the result payload while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // one item at a time: no transfer right after a transfer
  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while previous item in progress");

  // done ends the move and commands nothing
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[USR_DONE] |->
      !m_axis_tuser[USR_MOV] && !m_axis_tuser[USR_CV])
    else $error("done with move flags set");

  // no move in progress: payload is all zero
  a_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[USR_MOV] |-> m_axis_tdata == '0)
    else $error("nonzero payload without a move");

  // a command is only given during a move
  a_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[USR_CV] |-> m_axis_tuser[USR_MOV])
    else $error("command outside a move");

endmodule

bind segmented_linear_move_sequencer_core slms_checker #(
  .OUT_W(((3*POS_BITS+3*slms_pkg::SPEED_W+7)/8)*8)
) u_slms_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);
